### hdl/tlp_pkg.sv
// ----------------------------------------------------------------------------
// Turtle line plotter package
// Shared constants, codes, control structs and helper functions.
// ----------------------------------------------------------------------------
package tlp_pkg;

    localparam int CANVAS_WIDTH  = 128;
    localparam int CANVAS_HEIGHT = 64;

    localparam int FULL_TURN    = 46080;
    localparam int CORDIC_ITERS = 16;
    localparam int DIV_NUM_W    = 17;
    localparam int DIV_DEN_W    = 16;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [27:0] DEG90  = 28'sd5898240;
    localparam logic signed [27:0] DEG180 = 28'sd11796480;
    localparam logic signed [27:0] DEG270 = 28'sd17694720;
    localparam logic signed [27:0] DEG360 = 28'sd23592960;

    localparam logic [14:0] HOME_X_RST = 15'd12800;
    localparam logic [14:0] HOME_Y_RST = 15'd6400;

    localparam logic [1:0] CFG_HOME_X = 2'd0;
    localparam logic [1:0] CFG_HOME_Y = 2'd1;

    typedef enum logic [2:0] {
        CMD_FWD   = 3'd0,
        CMD_TURN  = 3'd1,
        CMD_PEN   = 3'd2,
        CMD_GOTO  = 3'd3,
        CMD_SETH  = 3'd4,
        CMD_CLEAR = 3'd5,
        CMD_READ  = 3'd6
    } t_cmd;

    typedef struct packed {
        logic clear;
        logic wr;
        logic rd;
    } t_canvas_req;

    typedef struct packed {
        logic busy;
        logic rd_bit;
    } t_canvas_sts;

    function automatic logic signed [27:0] atan_deg(input logic [3:0] idx);
        logic signed [27:0] v;
        unique case (idx)
            4'd0:  v = 28'sd2949120;
            4'd1:  v = 28'sd1740967;
            4'd2:  v = 28'sd919879;
            4'd3:  v = 28'sd466945;
            4'd4:  v = 28'sd234379;
            4'd5:  v = 28'sd117304;
            4'd6:  v = 28'sd58666;
            4'd7:  v = 28'sd29335;
            4'd8:  v = 28'sd14668;
            4'd9:  v = 28'sd7334;
            4'd10: v = 28'sd3667;
            4'd11: v = 28'sd1833;
            4'd12: v = 28'sd917;
            4'd13: v = 28'sd458;
            4'd14: v = 28'sd229;
            4'd15: v = 28'sd115;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] wrap_heading(input logic signed [18:0] v);
        logic signed [18:0] t;
        t = v;
        if (t < 0) t = t + 19'sd46080;
        if (t < 0) t = t + 19'sd46080;
        if (t >= 19'sd46080) t = t - 19'sd46080;
        if (t >= 19'sd46080) t = t - 19'sd46080;
        return t[15:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
        logic signed [15:0] r;
        if (v > 22'sd32767) r = 16'sh7fff;
        else if (v < -22'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

endpackage

### hdl/tlp_cordic.sv
// ----------------------------------------------------------------------------
// Turtle line plotter CORDIC rotator
// Iterative rotation giving cosine and sine of a heading, one step a cycle.
// ----------------------------------------------------------------------------
module tlp_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_heading,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);

    localparam logic signed [27:0] DEG90_L  = tlp_pkg::DEG90;
    localparam logic signed [27:0] DEG270_L = tlp_pkg::DEG270;

    logic signed [33:0] r_x, r_y;
    logic signed [27:0] r_z;
    logic [3:0]         r_i;
    logic               r_busy, r_neg, r_done;

    logic signed [27:0] z0, z_fold;
    logic               neg0;
    logic signed [33:0] xs, ys;
    logic signed [27:0] at;

    always_comb begin
        z0 = signed'({3'b000, i_heading, 9'b0});
        neg0 = 1'b0;
        z_fold = z0;
        if (z0 > DEG90_L && z0 < DEG270_L) begin
            z_fold = z0 - tlp_pkg::DEG180;
            neg0 = 1'b1;
        end else if (z0 >= DEG270_L) begin
            z_fold = z0 - tlp_pkg::DEG360;
        end
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = tlp_pkg::atan_deg(r_i);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= tlp_pkg::CORDIC_START;
                r_y    <= '0;
                r_z    <= z_fold;
                r_neg  <= neg0;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 4'd1;
                if (r_i == 4'(tlp_pkg::CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

### hdl/tlp_div.sv
// ----------------------------------------------------------------------------
// Turtle line plotter divider
// Restoring unsigned divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tlp_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tlp_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [tlp_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [tlp_pkg::DIV_NUM_W-1:0]  o_quo,
    output logic [tlp_pkg::DIV_DEN_W-1:0]  o_rem
);

    localparam int NW = tlp_pkg::DIV_NUM_W;
    localparam int DW = tlp_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem, r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;

    logic [DW:0]   rem_sh, rem_sub;
    logic          take;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NW-1]};
        take    = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= take ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                r_quo <= {r_quo[NW-2:0], take};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

### hdl/tlp_canvas.sv
// ----------------------------------------------------------------------------
// Turtle line plotter canvas
// One-bit canvas memory with a registered read and a clearing sweep.
// ----------------------------------------------------------------------------
module tlp_canvas #(
    parameter int CANVAS_WIDTH  = tlp_pkg::CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = tlp_pkg::CANVAS_HEIGHT,
    parameter int ADDR_W        = $clog2(CANVAS_WIDTH * CANVAS_HEIGHT)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlp_pkg::t_canvas_req i_req,
    input  logic [ADDR_W-1:0]    i_addr,
    output tlp_pkg::t_canvas_sts o_sts
);

    localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;

    logic              mem [DEPTH];
    logic [ADDR_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (i_req.clear) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + ADDR_W'(1);
            if (r_cnt == ADDR_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_cnt] <= 1'b0;
        end else if (i_req.wr) begin
            mem[i_addr] <= 1'b1;
        end
        if (i_req.rd) begin
            r_rd <= mem[i_addr];
        end
    end

    assign o_sts.busy   = r_busy;
    assign o_sts.rd_bit = r_rd;

endmodule

### hdl/turtle_line_plotter_unit.sv
// ----------------------------------------------------------------------------
// Turtle line plotter
// Drawing turtle with saturating Q8.8 position, Q9.7 heading and a pen,
// plotting pen-down forward moves into a one-bit canvas memory.
//
// Channel   Direction  Handshake                  Word
// input     in         i_in_valid / o_in_stall    command and its operands
// output    out        o_out_valid / i_out_stall  position, heading, pen, cell
// config    in         i_cfg_we                   home_x, home_y
//
// Forward runs the CORDIC, the multiply and move states, the divider setup
// state and both dividers, then writes each point of the line that lies on
// the canvas (|distance|/256 + 1 points, at least 2, at most 129); a pen-up
// forward stops after the move state. Clear and reset sweep the canvas one
// cell a cycle, with the input stalled. Other commands go straight to the done
// state. A finished word waits in the output register while the next command
// is taken; its result waits in the done state until the output register is
// free or its stall drops.
// ----------------------------------------------------------------------------
module turtle_line_plotter_unit #(
    parameter int CANVAS_WIDTH  = tlp_pkg::CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = tlp_pkg::CANVAS_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_cmd,
    input  logic signed [15:0] i_distance,
    input  logic signed [16:0] i_turn_angle,
    input  logic               i_pen_value,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    input  logic signed [16:0] i_new_heading,
    input  logic [5:0]         i_read_row,
    input  logic [6:0]         i_read_col,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic [15:0]        o_heading_out,
    output logic               o_pen_is_down,
    output logic               o_cell_marked,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [14:0]        i_cfg_data
);

    localparam int ADDR_W = $clog2(CANVAS_WIDTH * CANVAS_HEIGHT);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CORDIC = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_MOVE   = 9'b000001000,
        S_PREP   = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_PLOT   = 9'b001000000,
        S_CLEAR  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [14:0]        r_home_x, r_home_y;
    logic signed [15:0] r_x, r_y, r_nx, r_ny;
    logic [15:0]        r_head;
    logic               r_pen;
    logic               r_cell, r_read_pend;
    logic signed [15:0] r_dist;
    logic [7:0]         r_steps, r_i;
    logic [15:0]        r_den;
    logic signed [49:0] r_px, r_py;
    logic               r_dxneg, r_dyneg;
    logic signed [17:0] r_qx, r_qy, r_qdx, r_qdy;
    logic [16:0]        r_rx, r_ry, r_rdx, r_rdy;

    logic               r_out_valid;
    logic signed [15:0] r_out_x, r_out_y;
    logic [15:0]        r_out_head;
    logic               r_out_pen, r_out_cell;

    logic accept, cmd_fwd, read_ok, out_free;
    logic cordic_done, divx_done, divy_done;
    logic signed [33:0] cos_v, sin_v;
    logic [16:0] qx_m, qy_m;
    logic [15:0] rx_m, ry_m;

    logic signed [16:0] dx, dy;
    logic [16:0] dx_mag, dy_mag, dist_mag;
    logic [7:0]  steps_raw;
    logic signed [21:0] nx_w, ny_w;
    logic signed [17:0] col_t, row_t;
    logic [16:0] rx_sum, ry_sum;
    logic        col_ok, row_ok;
    logic [ADDR_W-1:0] plot_addr, read_addr;

    tlp_pkg::t_canvas_req canvas_req;
    tlp_pkg::t_canvas_sts canvas_sts;

    assign o_in_stall = (r_state != S_IDLE) || canvas_sts.busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign cmd_fwd    = i_cmd == tlp_pkg::CMD_FWD;
    assign read_ok    = (int'(i_read_row) < CANVAS_HEIGHT) && (int'(i_read_col) < CANVAS_WIDTH);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        dist_mag  = i_distance[15] ? 17'(-18'(i_distance)) : 17'(i_distance);
        steps_raw = 8'(dist_mag >> 8);
        dx     = 17'(r_nx) - 17'(r_x);
        dy     = 17'(r_ny) - 17'(r_y);
        dx_mag = dx[16] ? 17'(-dx) : 17'(dx);
        dy_mag = dy[16] ? 17'(-dy) : 17'(dy);
        nx_w   = 22'(r_x) + 22'((r_px + 50'sd536870912) >>> 30);
        ny_w   = 22'(r_y) + 22'((r_py + 50'sd536870912) >>> 30);
        col_t  = (r_qx < 0 && r_rx != '0) ? r_qx + 18'sd1 : r_qx;
        row_t  = (r_qy < 0 && r_ry != '0) ? r_qy + 18'sd1 : r_qy;
        col_ok = (col_t >= 0) && (int'(col_t) < CANVAS_WIDTH);
        row_ok = (row_t >= 0) && (int'(row_t) < CANVAS_HEIGHT);
        rx_sum = r_rx + r_rdx;
        ry_sum = r_ry + r_rdy;
        plot_addr = ADDR_W'($unsigned(row_t)) * ADDR_W'(CANVAS_WIDTH)
                  + ADDR_W'($unsigned(col_t));
        read_addr = ADDR_W'(i_read_row) * ADDR_W'(CANVAS_WIDTH) + ADDR_W'(i_read_col);
    end

    always_comb begin
        canvas_req.clear = accept && (i_cmd == tlp_pkg::CMD_CLEAR);
        canvas_req.rd    = accept && (i_cmd == tlp_pkg::CMD_READ) && read_ok;
        canvas_req.wr    = (r_state == S_PLOT) && col_ok && row_ok;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (cmd_fwd) n_state = S_CORDIC;
                    else if (i_cmd == tlp_pkg::CMD_CLEAR) n_state = S_CLEAR;
                    else n_state = S_DONE;
                end
            end
            S_CORDIC: begin
                if (cordic_done) n_state = S_MUL;
            end
            S_MUL:  n_state = S_MOVE;
            S_MOVE: n_state = r_pen ? S_PREP : S_DONE;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (divx_done && divy_done) n_state = S_PLOT;
            end
            S_PLOT: begin
                if (r_i == r_steps) n_state = S_DONE;
            end
            S_CLEAR: begin
                if (!canvas_sts.busy) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_home_x    <= tlp_pkg::HOME_X_RST;
            r_home_y    <= tlp_pkg::HOME_Y_RST;
            r_x         <= signed'({1'b0, tlp_pkg::HOME_X_RST});
            r_y         <= signed'({1'b0, tlp_pkg::HOME_Y_RST});
            r_head      <= '0;
            r_pen       <= 1'b1;
            r_read_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == tlp_pkg::CFG_HOME_X) r_home_x <= i_cfg_data;
                else if (i_cfg_addr == tlp_pkg::CFG_HOME_Y) r_home_y <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            r_read_pend <= canvas_req.rd;
            if (r_read_pend) r_cell <= canvas_sts.rd_bit;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cell  <= 1'b0;
                        r_dist  <= i_distance;
                        r_steps <= (steps_raw == '0) ? 8'd1 : steps_raw;
                        unique case (i_cmd)
                            tlp_pkg::CMD_TURN:
                                r_head <= tlp_pkg::wrap_heading(19'(signed'({1'b0, r_head}))
                                                                + 19'(i_turn_angle));
                            tlp_pkg::CMD_PEN:  r_pen <= i_pen_value;
                            tlp_pkg::CMD_GOTO: begin
                                r_x <= i_target_x;
                                r_y <= i_target_y;
                            end
                            tlp_pkg::CMD_SETH:
                                r_head <= tlp_pkg::wrap_heading(19'(i_new_heading));
                            tlp_pkg::CMD_CLEAR: begin
                                r_x    <= signed'({1'b0, r_home_x});
                                r_y    <= signed'({1'b0, r_home_y});
                                r_head <= '0;
                                r_pen  <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CORDIC: begin
                    if (cordic_done) begin
                        r_px <= 50'(r_dist) * 50'(cos_v);
                        r_py <= 50'(r_dist) * 50'(sin_v);
                    end
                end
                S_MUL: ;
                S_MOVE: begin
                    r_nx <= tlp_pkg::sat16(nx_w);
                    r_ny <= tlp_pkg::sat16(ny_w);
                    if (!r_pen) begin
                        r_x <= tlp_pkg::sat16(nx_w);
                        r_y <= tlp_pkg::sat16(ny_w);
                    end
                end
                S_PREP: begin
                    r_den   <= {r_steps, 8'b0};
                    r_dxneg <= dx[16];
                    r_dyneg <= dy[16];
                    r_qx    <= {{10{r_x[15]}}, r_x[15:8]};
                    r_qy    <= {{10{r_y[15]}}, r_y[15:8]};
                    r_rx    <= 17'(r_x[7:0] * r_steps);
                    r_ry    <= 17'(r_y[7:0] * r_steps);
                    r_i     <= '0;
                end
                S_DIV: begin
                    if (divx_done && divy_done) begin
                        if (!r_dxneg) begin
                            r_qdx <= signed'({1'b0, qx_m});
                            r_rdx <= {1'b0, rx_m};
                        end else if (rx_m == '0) begin
                            r_qdx <= -signed'({1'b0, qx_m});
                            r_rdx <= '0;
                        end else begin
                            r_qdx <= -signed'({1'b0, qx_m}) - 18'sd1;
                            r_rdx <= {1'b0, r_den - rx_m};
                        end
                        if (!r_dyneg) begin
                            r_qdy <= signed'({1'b0, qy_m});
                            r_rdy <= {1'b0, ry_m};
                        end else if (ry_m == '0) begin
                            r_qdy <= -signed'({1'b0, qy_m});
                            r_rdy <= '0;
                        end else begin
                            r_qdy <= -signed'({1'b0, qy_m}) - 18'sd1;
                            r_rdy <= {1'b0, r_den - ry_m};
                        end
                    end
                end
                S_PLOT: begin
                    r_i <= r_i + 8'd1;
                    if (rx_sum >= {1'b0, r_den}) begin
                        r_rx <= rx_sum - {1'b0, r_den};
                        r_qx <= r_qx + r_qdx + 18'sd1;
                    end else begin
                        r_rx <= rx_sum;
                        r_qx <= r_qx + r_qdx;
                    end
                    if (ry_sum >= {1'b0, r_den}) begin
                        r_ry <= ry_sum - {1'b0, r_den};
                        r_qy <= r_qy + r_qdy + 18'sd1;
                    end else begin
                        r_ry <= ry_sum;
                        r_qy <= r_qy + r_qdy;
                    end
                    if (r_i == r_steps) begin
                        r_x <= r_nx;
                        r_y <= r_ny;
                    end
                end
                S_CLEAR: ;
                S_DONE: begin
                    if (out_free) begin
                        r_out_x     <= r_x;
                        r_out_y     <= r_y;
                        r_out_head  <= r_head;
                        r_out_pen   <= r_pen;
                        r_out_cell  <= r_read_pend ? canvas_sts.rd_bit : r_cell;
                    end
                end
                default: ;
            endcase
        end
    end

    tlp_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept && cmd_fwd),
        .i_heading (r_head),
        .o_done    (cordic_done),
        .o_cos     (cos_v),
        .o_sin     (sin_v)
    );

    tlp_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_num   (dx_mag),
        .i_den   ({r_steps, 8'b0}),
        .o_done  (divx_done),
        .o_quo   (qx_m),
        .o_rem   (rx_m)
    );

    tlp_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_num   (dy_mag),
        .i_den   ({r_steps, 8'b0}),
        .o_done  (divy_done),
        .o_quo   (qy_m),
        .o_rem   (ry_m)
    );

    tlp_canvas #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT),
        .ADDR_W        (ADDR_W)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (canvas_req),
        .i_addr  ((r_state == S_PLOT) ? plot_addr : read_addr),
        .o_sts   (canvas_sts)
    );

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_out_x;
    assign o_pos_y       = r_out_y;
    assign o_heading_out = r_out_head;
    assign o_pen_is_down = r_out_pen;
    assign o_cell_marked = r_out_cell;

endmodule
